// ===== design/olde_pkg.sv =====
// shared types and codes for the ordered list deque engine
// operation codes, status codes and the cell control request; no dependencies
package olde_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_SEARCH     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD = 3'd0,
        CMD_SHR  = 3'd1,
        CMD_SHL  = 3'd2,
        CMD_ROT  = 3'd3,
        CMD_PUT  = 3'd4
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd   cmd;
        logic [31:0] data;
    } t_cell_ctl;

endpackage

// ===== design/olde_cell.sv =====
// one storage cell of the list chain: holds a single entry
// depends on olde_pkg for the cell control request
module olde_cell
    import olde_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    input  logic [31:0] i_head,
    output logic [31:0] o_val
);

    logic [31:0] r_val;
    logic [31:0] n_val;
    logic        w_is_last;
    logic        w_is_tail;

    // last valid entry and first free slot
    assign w_is_last = ((CW'(IDX) + 1'b1) == i_count);
    assign w_is_tail = (CW'(IDX) == i_count);

    always_comb begin
        case (i_ctl.cmd)
            CMD_HOLD: n_val = r_val;
            CMD_SHR:  n_val = i_left;
            CMD_SHL:  n_val = i_right;
            CMD_ROT:  n_val = w_is_last ? i_head : i_right;
            CMD_PUT:  n_val = w_is_tail ? i_ctl.data : r_val;
            default:  n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// ===== design/olde_chain.sv =====
// row of list cells, each linked to its left and right neighbour
// depends on olde_pkg and olde_cell
module olde_chain
    import olde_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    output logic [31:0]   o_head
);

    logic [31:0] w_val [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctl.data;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        olde_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_val[0]),
            .o_val   (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

// ===== design/ordered_list_deque_engine_top.sv =====
// push and pop requests give their result in the cycle after acceptance
// delete and search rotate the whole list once past the head cell, one step per
// entry, then give their result once the result slot is free (at once if empty)
// one push/pop request per cycle unless the result side stalls; none in a scan
// reset clears the entry count, the controller and the result valid at once;
// cell contents are not reset and need no clearing pass
module ordered_list_deque_engine_top
    import olde_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [6:0]         o_length
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic          r_hit, n_hit;
    t_op           r_op, n_op;
    logic [31:0]   r_key, n_key;
    logic          r_out_valid, n_out_valid;
    t_status       r_status, n_status;
    logic          r_found, n_found;
    logic [6:0]    r_length, n_length;

    t_cell_ctl     w_ctl;
    logic [31:0]   w_head;
    logic          w_accept;
    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic          w_write;
    logic          w_match;
    logic [CW+6:0] w_len_ext;

    // result slot frees when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_cnt == CW'(CAPACITY));
    assign w_empty    = (r_cnt == '0);
    // head cell compare, only until the first hit
    assign w_match    = !r_hit && (w_head == r_key);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_hit       = r_hit;
        n_op        = r_op;
        n_key       = r_key;
        n_status    = r_status;
        n_found     = r_found;
        w_write     = 1'b0;
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.data  = $unsigned(i_value);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_write  = 1'b1;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    case (t_op'(i_operation))
                        OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.cmd = CMD_SHR;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.cmd = CMD_PUT;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctl.cmd = CMD_SHL;
                                n_cnt     = r_cnt - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - 1'b1;
                            end
                        end
                        OP_DELETE, OP_SEARCH: begin
                            if (w_empty) begin
                                // nothing to scan: answer at once
                                if (t_op'(i_operation) == OP_DELETE) begin
                                    n_status = ST_NOTFOUND;
                                end
                            end else begin
                                // start one full rotation of the list
                                w_write = 1'b0;
                                n_state = S_SCAN;
                                n_left  = r_cnt;
                                n_hit   = 1'b0;
                                n_op    = t_op'(i_operation);
                                n_key   = $unsigned(i_value);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                    if (w_match) begin
                        n_hit = 1'b1;
                    end
                    if (w_match && (r_op == OP_DELETE)) begin
                        // drop the head instead of wrapping it round
                        w_ctl.cmd = CMD_SHL;
                        n_cnt     = r_cnt - 1'b1;
                    end else begin
                        w_ctl.cmd = CMD_ROT;
                    end
                end else if (w_out_free) begin
                    w_write = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_DELETE) begin
                        n_status = r_hit ? ST_OK : ST_NOTFOUND;
                        n_found  = 1'b0;
                    end else begin
                        n_status = ST_OK;
                        n_found  = r_hit;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // length port carries the count modulo 128
    assign w_len_ext   = {{7{1'b0}}, n_cnt};
    assign n_length    = w_write ? w_len_ext[6:0] : r_length;
    assign n_out_valid = w_write || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_left      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_found  <= n_found;
        r_length <= n_length;
    end

    olde_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_cnt),
        .o_head  (w_head)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_length    = r_length;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left <= r_cnt))
        else $error("scan steps left exceed list length");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty &&
         ((i_operation == OP_DELETE) || (i_operation == OP_SEARCH)))
        |=> (r_state == S_SCAN))
        else $error("scan request did not start a scan");

    a_search_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (r_op == OP_SEARCH)) |=> $stable(r_cnt))
        else $error("search changed the list length");

    a_no_result_mid_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (r_left != '0)) |=> !$rose(r_out_valid))
        else $error("result raised before scan finished");
`endif

endmodule

// ===== verif/olde_result_checker.sv =====
// result checker for the ordered list deque engine: keeps its own copy of the list,
// predicts one result per accepted request and compares the results the block returns
// depends on olde_pkg for the operation and status codes
`timescale 1ns / 100ps
module olde_result_checker
    import olde_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic        i_found,
    input  logic [6:0]  i_length,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_peak_length
);

    typedef struct {
        t_status    status;
        logic       found;
        logic [6:0] length;
    } t_list_result;

    logic [31:0]  list_contents[$];
    t_list_result due_results[$];

    // applies one request to the local list and returns the result it should give
    function automatic t_list_result apply_list_op(input logic [2:0] op,
                                                   input logic [31:0] val);
        t_list_result res;
        int           hit_pos;
        res.status = ST_OK;
        res.found  = 1'b0;
        hit_pos    = -1;
        foreach (list_contents[k]) begin
            if (hit_pos < 0 && list_contents[k] == val) begin
                hit_pos = k;
            end
        end
        case (op)
            OP_PUSH_FRONT: begin
                if (list_contents.size() >= CAPACITY) res.status = ST_FULL;
                else list_contents.push_front(val);
            end
            OP_PUSH_BACK: begin
                if (list_contents.size() >= CAPACITY) res.status = ST_FULL;
                else list_contents.push_back(val);
            end
            OP_POP_FRONT: begin
                if (list_contents.size() == 0) res.status = ST_EMPTY;
                else void'(list_contents.pop_front());
            end
            OP_POP_BACK: begin
                if (list_contents.size() == 0) res.status = ST_EMPTY;
                else void'(list_contents.pop_back());
            end
            OP_DELETE: begin
                if (hit_pos < 0) res.status = ST_NOTFOUND;
                else list_contents.delete(hit_pos);
            end
            OP_SEARCH: begin
                res.found = (hit_pos >= 0);
            end
            default: begin
            end
        endcase
        res.length = 7'(list_contents.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_contents.delete();
            due_results.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_peak_length = 0;
        end else begin
            // compare first: a result can never belong to a request taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: status %0d found %0d length %0d",
                           i_status, i_found, i_length);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    o_checked++;
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d",
                               want.found, i_found);
                        o_fail_count++;
                    end
                    if (i_length !== want.length) begin
                        $error("length mismatch: expected %0d, actual %0d",
                               want.length, i_length);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(apply_list_op(i_operation, i_value));
                if (list_contents.size() > o_peak_length) begin
                    o_peak_length = list_contents.size();
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ===== verif/ordered_list_deque_engine_top_tb.sv =====
// testbench top for the ordered list deque engine: clock, reset, request stimulus,
// result-side stall and the final verdict; checking lives in olde_result_checker
// depends on olde_pkg, olde_result_checker and ordered_list_deque_engine_top
`timescale 1ns / 100ps
module ordered_list_deque_engine_top_tb;
    import olde_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1300;
    // watchdog limit: many times the length of the slowest run
    localparam int CYCLE_LIMIT  = 600000;
    // settle time after the last result: longer than the longest scan
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    // operation codes the block does not define: they must act as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // mix of operations for a stretch of random requests
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED,
        MIX_SCAN
    } t_phase_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_operation;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic               o_found;
    logic [6:0]         o_length;

    int fail_count;
    int pending_results;
    int checked_results;
    int peak_length;
    int cycle_count;
    int req_count[8];

    // set during a stretch of the run where neither side idles
    logic calm;

    // small set of values reused often so that search and delete hit entries,
    // including duplicates; the extremes of the value range sit in the first slots
    logic [31:0] value_pool[16];

    ordered_list_deque_engine_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operation(i_operation),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_length   (o_length)
    );

    olde_result_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_found      (o_found),
        .i_length     (o_length),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_results),
        .o_peak_length(peak_length)
    );

    // 8 ns clock period
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends the run here
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ordered_list_deque_engine_top] ERROR");
            $finish;
        end
    end

    // result side stalls about one cycle in ten, never while calm
    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 10);
    end

    // one request: optional idle cycles, then valid held with a stable payload until
    // taken; called and returns at a falling edge
    task automatic send_request(input logic [2:0] op, input logic [31:0] val);
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_value     = val;
        req_count[op]++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 60) return value_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    // weighted choice of operation for the current mix; a few spare codes as noise
    function automatic logic [2:0] pick_operation(input t_phase_mix mix);
        int roll;
        int push_weight;
        int pop_weight;
        roll = $urandom_range(99);
        case (mix)
            MIX_GROW:     begin push_weight = 88; pop_weight = 4;  end
            MIX_SHRINK:   begin push_weight = 10; pop_weight = 58; end
            MIX_BALANCED: begin push_weight = 36; pop_weight = 30; end
            default:      begin push_weight = 22; pop_weight = 12; end
        endcase
        if (roll < 2) return $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        if (roll < 2 + push_weight) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (roll < 2 + push_weight + pop_weight) begin
            return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        return $urandom_range(1) ? OP_SEARCH : OP_DELETE;
    endfunction

    initial begin
        int         issued;
        int         phase_left;
        t_phase_mix mix;

        // every input known from time zero, reset held from the start
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_PUSH_FRONT;
        i_value     = '0;
        calm        = 1'b0;
        foreach (req_count[k]) req_count[k] = 0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int k = 4; k < 16; k++) value_pool[k] = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        // empty list: both pops report empty, delete reports not found, search misses
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_POP_BACK, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0000_0005);
        send_request(OP_SEARCH, 32'h0000_0000);
        // spare codes leave everything alone
        send_request(OP_SPARE_6, 32'h1234_5678);
        send_request(OP_SPARE_7, 32'hFFFF_FFFF);
        // value extremes at both ends, with a duplicate
        send_request(OP_PUSH_FRONT, 32'h8000_0000);
        send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h0000_0000);
        send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
        // search hit and miss, delete of the first of two equal entries, delete miss
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h0000_0001);
        send_request(OP_DELETE, 32'h7FFF_FFFF);
        send_request(OP_DELETE, 32'h0000_3039);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        // drain from both ends, then pop once more on the empty list
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_POP_BACK, 32'h0);
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_POP_BACK, 32'h0);
        send_request(OP_POP_FRONT, 32'h0);
        send_request(OP_PUSH_FRONT, 32'h5555_5555);
        send_request(OP_PUSH_BACK, 32'hAAAA_AAAA);
        wait_results_drained();

        // random part: stretches of one mix; the first grows well past capacity so
        // inserts into a full list are seen early
        issued     = 0;
        mix        = MIX_GROW;
        phase_left = 90;
        while (issued < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                mix        = t_phase_mix'($urandom_range(3));
                phase_left = $urandom_range(120, 40);
            end
            // a quiet stretch with no idling on either side
            calm = (issued >= 500 && issued < 800);
            // sender pause mid-run until the block has answered everything
            if (issued == 650) wait_results_drained();
            send_request(pick_operation(mix), pick_value());
            issued++;
            phase_left--;
        end
        calm = 1'b0;

        // wait for the last results, then give any stray output time to show up
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("requests: push front %0d, push back %0d, pop front %0d, pop back %0d",
                 req_count[OP_PUSH_FRONT], req_count[OP_PUSH_BACK],
                 req_count[OP_POP_FRONT], req_count[OP_POP_BACK]);
        $display("delete %0d, search %0d, spare codes %0d; %0d results checked, peak length %0d",
                 req_count[OP_DELETE], req_count[OP_SEARCH],
                 req_count[OP_SPARE_6] + req_count[OP_SPARE_7],
                 checked_results, peak_length);
        if (fail_count == 0) begin
            $display("[ordered_list_deque_engine_top] OK");
        end else begin
            $display("[ordered_list_deque_engine_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/olde_pkg.sv
design/olde_cell.sv
design/olde_chain.sv
design/ordered_list_deque_engine_top.sv
verif/olde_result_checker.sv
verif/ordered_list_deque_engine_top_tb.sv
